/* src/stts_pkg.sv */
// Package for the sleep/tick thread scheduler: stream field widths, command and
// slot status codes, the sequencer state type and the result record.
// Has no dependencies of its own.
`default_nettype none

package stts_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Field widths of the stream items.
    localparam int CMD_W   = 3;
    localparam int TICKS_W = 16;
    localparam int SLOT_FW = 3;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_EXIT   = 3'd1,
        CMD_SLEEP  = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        SL_FREE   = 2'd0,
        SL_ACTIVE = 2'd1,
        SL_SLEEP  = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              slot_busy;
        logic              create_failed;
        logic [SLOT_FW-1:0] created_slot;
        logic              switched;
        logic [SLOT_FW-1:0] running_slot;
    } t_result;

endpackage

`default_nettype wire

/* src/sleep_tick_thread_scheduler_unit.sv */
// Thread slot scheduler with sleep countdowns; the slot table lives in one
// synchronous memory that a sequencer reads, updates and writes back.
// Depends on stts_pkg.
//
//  Channel   Dir  Signals                          Carries
//  s (in)    in   i_s_tvalid/o_s_tready/i_s_tdata  command, sleep_ticks, slot_index
//  m (out)   out  o_m_tvalid/i_m_tready/o_m_tdata  running_slot .. slot_busy
//
// A tick walks every slot, one memory read per cycle. A create walks from
// slot 1 to the first free slot; a query reads only the slot that it names,
// if in range; exit, sleep and unknown commands read no slot. A new command
// is accepted while the previous result still waits in the output register.
// Reset clears all slots to free at once through per-slot valid bits; no
// clearing pass is needed.
`default_nettype none

module sleep_tick_thread_scheduler_unit #(
    parameter int SLOTS      = stts_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = stts_pkg::COUNT_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // Fields from bit 0: command[2:0], sleep_ticks[18:3], slot_index[21:19].
    input  wire logic [stts_pkg::IN_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // Fields from bit 0: running_slot[2:0], switched[3], created_slot[6:4],
    // create_failed[7], slot_busy[8].
    output logic [stts_pkg::OUT_W-1:0]     o_m_tdata
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ADDR_W  = SLOT_W + 1;
    localparam int ENTRY_W = COUNT_BITS + 2;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] ADDR_END  = ADDR_W'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    // Slot table: status in the top two bits, sleep countdown below.
    logic [ENTRY_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]   r_valid;

    stts_pkg::t_state  r_state, n_state;
    stts_pkg::t_cmd    r_cmd, n_cmd;
    logic [COUNT_BITS-1:0] r_ticks, n_ticks;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic              r_found, n_found;
    logic [SLOT_W-1:0] r_next, n_next;
    stts_pkg::t_result r_res, n_res;
    stts_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic               r_chk;
    logic [SLOT_W-1:0]  r_chk_addr;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_vld;

    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    stts_pkg::t_cmd            in_cmd;
    logic [stts_pkg::TICKS_W-1:0] in_ticks;
    logic [stts_pkg::SLOT_FW-1:0] in_qidx;
    logic [31:0]               ticks_wide;
    logic [COUNT_BITS-1:0]     ticks_sat;

    stts_pkg::t_slot_st    chk_st;
    logic [COUNT_BITS-1:0] chk_cnt;
    stts_pkg::t_slot_st    tk_st;
    logic [COUNT_BITS-1:0] tk_cnt;
    logic                  tk_take;
    logic                  fin_found;
    logic [SLOT_W-1:0]     fin_next;

    assign in_cmd   = stts_pkg::t_cmd'(i_s_tdata[2:0]);
    assign in_ticks = i_s_tdata[18:3];
    assign in_qidx  = i_s_tdata[21:19];

    // A zero count sleeps one tick; a count beyond the counter saturates.
    assign ticks_wide = (in_ticks == '0) ? 32'd1 : 32'(in_ticks);
    assign ticks_sat  = (ticks_wide > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                 : ticks_wide[COUNT_BITS-1:0];

    // An entry never written since reset reads as a free slot.
    assign chk_st  = r_rd_vld ? stts_pkg::t_slot_st'(r_rd_data[ENTRY_W-1:COUNT_BITS])
                              : stts_pkg::SL_FREE;
    assign chk_cnt = r_rd_vld ? r_rd_data[COUNT_BITS-1:0] : '0;

    always_comb begin
        tk_st  = chk_st;
        tk_cnt = chk_cnt;
        if (chk_st == stts_pkg::SL_SLEEP) begin
            if (chk_cnt <= COUNT_BITS'(1)) begin
                tk_st  = stts_pkg::SL_ACTIVE;
                tk_cnt = '0;
            end else begin
                tk_cnt = chk_cnt - COUNT_BITS'(1);
            end
        end
    end

    assign tk_take   = (tk_st == stts_pkg::SL_ACTIVE) && (r_chk_addr != r_cur) && !r_found;
    assign fin_found = r_found || tk_take;
    assign fin_next  = tk_take ? r_chk_addr : r_next;

    assign o_s_tready = (r_state == stts_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = stts_pkg::OUT_W'(r_out);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ticks     = r_ticks;
        n_addr      = r_addr;
        n_cur       = r_cur;
        n_found     = r_found;
        n_next      = r_next;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        rd_en       = 1'b0;
        rd_addr     = r_addr[SLOT_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        case (r_state)
            stts_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = in_cmd;
                    n_ticks = ticks_sat;
                    n_res   = '0;
                    n_state = stts_pkg::S_DONE;
                    case (in_cmd)
                        stts_pkg::CMD_CREATE: begin
                            n_addr  = ADDR_W'(1);
                            n_state = stts_pkg::S_WALK;
                        end
                        stts_pkg::CMD_EXIT: begin
                            if (r_cur != '0) begin
                                wr_en   = 1'b1;
                                wr_addr = r_cur;
                                wr_data = {stts_pkg::SL_FREE, {COUNT_BITS{1'b0}}};
                            end
                        end
                        stts_pkg::CMD_SLEEP: begin
                            if (r_cur != '0) begin
                                wr_en   = 1'b1;
                                wr_addr = r_cur;
                                wr_data = {stts_pkg::SL_SLEEP, ticks_sat};
                                n_cur   = '0;
                            end
                        end
                        stts_pkg::CMD_TICK: begin
                            n_addr  = '0;
                            n_found = 1'b0;
                            n_next  = '0;
                            n_state = stts_pkg::S_WALK;
                        end
                        stts_pkg::CMD_QUERY: begin
                            if (32'(in_qidx) < 32'(SLOTS)) begin
                                n_addr  = ADDR_W'(in_qidx);
                                n_state = stts_pkg::S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.running_slot = stts_pkg::SLOT_FW'(n_cur);
                end
            end

            stts_pkg::S_WALK: begin
                // Reads run one slot ahead of the slot being updated.
                if (r_addr < ADDR_END) begin
                    rd_en  = 1'b1;
                    n_addr = (r_cmd == stts_pkg::CMD_QUERY) ? ADDR_END
                                                            : r_addr + ADDR_W'(1);
                end
                if (r_chk) begin
                    case (r_cmd)
                        stts_pkg::CMD_CREATE: begin
                            if (chk_st == stts_pkg::SL_FREE) begin
                                wr_en   = 1'b1;
                                wr_addr = r_chk_addr;
                                wr_data = {stts_pkg::SL_ACTIVE, {COUNT_BITS{1'b0}}};
                                n_res.created_slot = stts_pkg::SLOT_FW'(r_chk_addr);
                                n_state = stts_pkg::S_DONE;
                            end else if (r_chk_addr == SLOT_LAST) begin
                                n_res.create_failed = 1'b1;
                                n_state = stts_pkg::S_DONE;
                            end
                        end
                        stts_pkg::CMD_TICK: begin
                            wr_en   = 1'b1;
                            wr_addr = r_chk_addr;
                            wr_data = {tk_st, tk_cnt};
                            n_found = fin_found;
                            n_next  = fin_next;
                            if (r_chk_addr == SLOT_LAST) begin
                                if (fin_found && fin_next != '0) begin
                                    n_cur          = fin_next;
                                    n_res.switched = 1'b1;
                                end
                                n_res.running_slot = stts_pkg::SLOT_FW'(n_cur);
                                n_state = stts_pkg::S_DONE;
                            end
                        end
                        stts_pkg::CMD_QUERY: begin
                            n_res.slot_busy = (chk_st != stts_pkg::SL_FREE);
                            n_state = stts_pkg::S_DONE;
                        end
                        default: begin
                            n_state = stts_pkg::S_DONE;
                        end
                    endcase
                end
            end

            stts_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = stts_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = stts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stts_pkg::S_IDLE;
            r_cur       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_chk       <= rd_en;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ticks    <= n_ticks;
        r_addr     <= n_addr;
        r_next     <= n_next;
        r_res      <= n_res;
        r_out      <= n_out;
        r_chk_addr <= rd_addr;
    end

    // Slot table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
        end
    end

    a_no_rw_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en && wr_addr == rd_addr))
        else $error("slot table read and written at the same entry");

    a_slot0_stays_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && wr_addr == '0) |-> (wr_data[ENTRY_W-1:COUNT_BITS] == stts_pkg::SL_FREE))
        else $error("slot zero written with a status other than free");

    a_chk_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> (r_state == stts_pkg::S_WALK || r_state == stts_pkg::S_DONE))
        else $error("read data returned outside a slot walk");

    a_create_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.create_failed && r_out.created_slot != '0))
        else $error("create reported both a slot and a failure");

endmodule

`default_nettype wire
